// File: rtl/positional_linked_list_top_defines.svh
// Assertion macros shared by the positional linked list RTL.
// Included by the top level; needs nothing else.
`ifndef POSITIONAL_LINKED_LIST_TOP_DEFINES_SVH
`define POSITIONAL_LINKED_LIST_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PLL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pll_pkg.sv
// Shared types and constants of the positional linked list.
// Used by the controller, the datapath and the top level.
package pll_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int CMD_W        = 3;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 9;
  localparam int LEN_W        = 9;
  localparam int ST_W         = 2;
  localparam int S_TDATA_W    = 48;
  localparam int M_TDATA_W    = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_POS   = 3'd1,
    CMD_INS_END   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_POS   = 3'd4,
    CMD_DEL_END   = 3'd5,
    CMD_READ      = 3'd6
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Datapath operation for one cycle.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_START,
    DP_WALK,
    DP_RD_CAP,
    DP_ALLOC,
    DP_ALLOC_POP,
    DP_LINK_FRONT,
    DP_LINK_NEW,
    DP_LINK_PREV,
    DP_DEL_FRONT,
    DP_VICT_RD,
    DP_VICT_UNLINK,
    DP_VICT_FREE,
    DP_EMIT
  } dp_op_e;

  // Number of link hops taken from the first node.
  typedef enum logic [2:0] {
    HOP_ZERO,
    HOP_POS_M1,
    HOP_POS_M2,
    HOP_CNT_M1,
    HOP_CNT_M2
  } hop_sel_e;

  typedef enum logic [2:0] {
    K_NONE,
    K_INS_FRONT,
    K_INS_AFTER,
    K_DEL_FRONT,
    K_DEL_MID,
    K_READ
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_RD_CAP,
    S_ALLOC,
    S_ALLOC_POP,
    S_LINK_FRONT,
    S_LINK_NEW,
    S_LINK_PREV,
    S_DEL_FRONT,
    S_VICT_RD,
    S_VICT_UNLINK,
    S_VICT_FREE,
    S_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e   op;
    hop_sel_e hop_sel;
    status_e  res;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             pos_ok;
    logic             pos_one;
    logic             cnt_one;
    logic             walk_last;
    logic             free_avail;
    logic             out_busy;
  } dp_stat_t;

endpackage

// File: rtl/pll_ctrl.sv
// Controller state machine of the positional linked list.
// Depends on pll_pkg; drives the datapath through ctrl_t.
module pll_ctrl
  import pll_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output ctrl_t    ctrl_o
);

  state_e   state_q, state_d;
  kind_e    kind_q, kind_d;
  kind_e    dec_kind;
  hop_sel_e dec_hop;
  status_e  dec_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_NONE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // Command decode: picks the error code, the job and the walk length.
  always_comb begin
    dec_kind = K_NONE;
    dec_hop  = HOP_ZERO;
    dec_res  = ST_OK;
    unique case (stat_i.cmd)
      CMD_INS_FRONT: begin
        if (stat_i.full) dec_res = ST_FULL;
        else dec_kind = K_INS_FRONT;
      end
      CMD_INS_POS: begin
        if (!stat_i.pos_ok) dec_res = ST_BAD_POS;
        else if (stat_i.full) dec_res = ST_FULL;
        else if (stat_i.pos_one) dec_kind = K_INS_FRONT;
        else begin
          dec_kind = K_INS_AFTER;
          dec_hop  = HOP_POS_M2;
        end
      end
      CMD_INS_END: begin
        if (stat_i.full) dec_res = ST_FULL;
        else if (stat_i.empty) dec_kind = K_INS_FRONT;
        else begin
          dec_kind = K_INS_AFTER;
          dec_hop  = HOP_CNT_M1;
        end
      end
      CMD_DEL_FRONT: begin
        if (stat_i.empty) dec_res = ST_EMPTY;
        else dec_kind = K_DEL_FRONT;
      end
      CMD_DEL_POS: begin
        if (stat_i.empty) dec_res = ST_EMPTY;
        else if (!stat_i.pos_ok) dec_res = ST_BAD_POS;
        else if (stat_i.pos_one) dec_kind = K_DEL_FRONT;
        else begin
          dec_kind = K_DEL_MID;
          dec_hop  = HOP_POS_M2;
        end
      end
      CMD_DEL_END: begin
        if (stat_i.empty) dec_res = ST_EMPTY;
        else if (stat_i.cnt_one) dec_kind = K_DEL_FRONT;
        else begin
          dec_kind = K_DEL_MID;
          dec_hop  = HOP_CNT_M2;
        end
      end
      CMD_READ: begin
        if (stat_i.empty) dec_res = ST_EMPTY;
        else if (!stat_i.pos_ok) dec_res = ST_BAD_POS;
        else begin
          dec_kind = K_READ;
          dec_hop  = HOP_POS_M1;
        end
      end
      default: begin
        dec_kind = K_NONE;
      end
    endcase
  end

  always_comb begin
    state_d        = state_q;
    kind_d         = kind_q;
    ctrl_o.op      = DP_NOP;
    ctrl_o.hop_sel = dec_hop;
    ctrl_o.res     = dec_res;
    in_ready_o     = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.op = DP_LOAD;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        ctrl_o.op = DP_START;
        kind_d    = dec_kind;
        state_d   = (dec_kind == K_NONE) ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        ctrl_o.op = DP_WALK;
        if (stat_i.walk_last) begin
          unique case (kind_q)
            K_INS_FRONT, K_INS_AFTER: state_d = S_ALLOC;
            K_DEL_FRONT:              state_d = S_DEL_FRONT;
            K_DEL_MID:                state_d = S_VICT_RD;
            K_READ:                   state_d = S_RD_CAP;
            default:                  state_d = S_FINISH;
          endcase
        end
      end
      S_RD_CAP: begin
        ctrl_o.op = DP_RD_CAP;
        state_d   = S_FINISH;
      end
      S_ALLOC: begin
        ctrl_o.op = DP_ALLOC;
        if (stat_i.free_avail) state_d = S_ALLOC_POP;
        else state_d = (kind_q == K_INS_FRONT) ? S_LINK_FRONT : S_LINK_NEW;
      end
      S_ALLOC_POP: begin
        ctrl_o.op = DP_ALLOC_POP;
        state_d   = (kind_q == K_INS_FRONT) ? S_LINK_FRONT : S_LINK_NEW;
      end
      S_LINK_FRONT: begin
        ctrl_o.op = DP_LINK_FRONT;
        state_d   = S_FINISH;
      end
      S_LINK_NEW: begin
        ctrl_o.op = DP_LINK_NEW;
        state_d   = S_LINK_PREV;
      end
      S_LINK_PREV: begin
        ctrl_o.op = DP_LINK_PREV;
        state_d   = S_FINISH;
      end
      S_DEL_FRONT: begin
        ctrl_o.op = DP_DEL_FRONT;
        state_d   = S_FINISH;
      end
      S_VICT_RD: begin
        ctrl_o.op = DP_VICT_RD;
        state_d   = S_VICT_UNLINK;
      end
      S_VICT_UNLINK: begin
        ctrl_o.op = DP_VICT_UNLINK;
        state_d   = S_VICT_FREE;
      end
      S_VICT_FREE: begin
        ctrl_o.op = DP_VICT_FREE;
        state_d   = S_FINISH;
      end
      S_FINISH: begin
        // Wait until the output register can take the result.
        if (!stat_i.out_busy) begin
          ctrl_o.op = DP_EMIT;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pll_dp.sv
// Datapath of the positional linked list: node memories, list pointers
// and output register. Depends on pll_pkg; steered by pll_ctrl.
module pll_dp
  import pll_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  output dp_stat_t         stat_o,
  input  logic [CMD_W-1:0] in_cmd_i,
  input  logic [VAL_W-1:0] in_value_i,
  input  logic [POS_W-1:0] in_pos_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ST_W-1:0]  out_status_o,
  output logic [LEN_W-1:0] out_length_o,
  output logic [VAL_W-1:0] out_value_o
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int IDX_W  = $clog2(CAPACITY + 1);
  localparam int CNT_W  = IDX_W;
  localparam int WIDE_W = POS_W + CNT_W;
  localparam int EXT_W  = LEN_W + CNT_W;
  localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

  logic [VAL_W-1:0] node_values [CAPACITY];
  logic [IDX_W-1:0] node_links  [CAPACITY];

  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] first_q, first_d, free_q, free_d, fresh_q, fresh_d;
  logic [IDX_W-1:0] cur_q, cur_d, nxt_q, nxt_d, new_q, new_d;
  logic [CNT_W-1:0] count_q, count_d, hops_q, hops_d;
  status_e          status_q, status_d;
  logic [VAL_W-1:0] rd_q, rd_d;
  logic             ov_q, ov_d;
  logic [ST_W-1:0]  ost_q, ost_d;
  logic [LEN_W-1:0] olen_q, olen_d;
  logic [VAL_W-1:0] oval_q, oval_d;

  logic [IDX_W-1:0] lnk_rdata_q, lnk_raddr, lnk_waddr, lnk_wdata;
  logic             lnk_we;
  logic [VAL_W-1:0] val_rdata_q;
  logic             val_we;

  logic [WIDE_W-1:0] pos_w, cnt_w;
  logic [CNT_W-1:0]  pos_c, hop_val;
  logic [EXT_W-1:0]  cnt_ext;
  logic              free_avail;

  // Node memories: one write and one registered read each per cycle.
  always_ff @(posedge clk_i) begin
    if (lnk_we) node_links[lnk_waddr[ADDR_W-1:0]] <= lnk_wdata;
    lnk_rdata_q <= node_links[lnk_raddr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) node_values[new_d[ADDR_W-1:0]] <= value_q;
    val_rdata_q <= node_values[cur_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= NIL;
      free_q  <= NIL;
      fresh_q <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      first_q <= first_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    value_q  <= value_d;
    pos_q    <= pos_d;
    cur_q    <= cur_d;
    nxt_q    <= nxt_d;
    new_q    <= new_d;
    hops_q   <= hops_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    ost_q    <= ost_d;
    olen_q   <= olen_d;
    oval_q   <= oval_d;
  end

  assign pos_w      = WIDE_W'(pos_q);
  assign cnt_w      = WIDE_W'(count_q);
  assign pos_c      = pos_w[CNT_W-1:0];
  assign cnt_ext    = EXT_W'(count_q);
  assign free_avail = (free_q != NIL);

  always_comb begin
    unique case (ctrl_i.hop_sel)
      HOP_POS_M1: hop_val = pos_c - CNT_W'(1);
      HOP_POS_M2: hop_val = pos_c - CNT_W'(2);
      HOP_CNT_M1: hop_val = count_q - CNT_W'(1);
      HOP_CNT_M2: hop_val = count_q - CNT_W'(2);
      default:    hop_val = '0;
    endcase
  end

  assign stat_o.cmd        = cmd_q;
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (cnt_w >= WIDE_W'(CAPACITY));
  assign stat_o.pos_ok     = (pos_q != '0) && (pos_w <= cnt_w);
  assign stat_o.pos_one    = (pos_w == WIDE_W'(1));
  assign stat_o.cnt_one    = (count_q == CNT_W'(1));
  assign stat_o.walk_last  = (hops_q == '0);
  assign stat_o.free_avail = free_avail;
  assign stat_o.out_busy   = ov_q && !out_ready_i;

  always_comb begin
    cmd_d     = cmd_q;
    value_d   = value_q;
    pos_d     = pos_q;
    first_d   = first_q;
    free_d    = free_q;
    fresh_d   = fresh_q;
    cur_d     = cur_q;
    nxt_d     = nxt_q;
    new_d     = new_q;
    count_d   = count_q;
    hops_d    = hops_q;
    status_d  = status_q;
    rd_d      = rd_q;
    ov_d      = ov_q && !out_ready_i;
    ost_d     = ost_q;
    olen_d    = olen_q;
    oval_d    = oval_q;
    lnk_raddr = cur_q;
    lnk_we    = 1'b0;
    lnk_waddr = cur_q;
    lnk_wdata = free_q;
    val_we    = 1'b0;
    unique case (ctrl_i.op)
      DP_LOAD: begin
        cmd_d   = in_cmd_i;
        value_d = in_value_i;
        pos_d   = in_pos_i;
      end
      DP_START: begin
        cur_d     = first_q;
        lnk_raddr = first_q;
        hops_d    = hop_val;
        status_d  = ctrl_i.res;
        rd_d      = '0;
      end
      DP_WALK: begin
        // The read data always holds the link of cur_q here, so the
        // chase advances one node per cycle.
        if (hops_q != '0) begin
          cur_d     = lnk_rdata_q;
          lnk_raddr = lnk_rdata_q;
          hops_d    = hops_q - CNT_W'(1);
        end else begin
          nxt_d = lnk_rdata_q;
        end
      end
      DP_RD_CAP: begin
        rd_d = val_rdata_q;
      end
      DP_ALLOC: begin
        new_d  = free_avail ? free_q : fresh_q;
        val_we = 1'b1;
        if (free_avail) lnk_raddr = free_q;
        else fresh_d = fresh_q + IDX_W'(1);
      end
      DP_ALLOC_POP: begin
        free_d = lnk_rdata_q;
      end
      DP_LINK_FRONT: begin
        lnk_we    = 1'b1;
        lnk_waddr = new_q;
        lnk_wdata = first_q;
        first_d   = new_q;
        count_d   = count_q + CNT_W'(1);
      end
      DP_LINK_NEW: begin
        lnk_we    = 1'b1;
        lnk_waddr = new_q;
        lnk_wdata = nxt_q;
      end
      DP_LINK_PREV: begin
        lnk_we    = 1'b1;
        lnk_waddr = cur_q;
        lnk_wdata = new_q;
        count_d   = count_q + CNT_W'(1);
      end
      DP_DEL_FRONT: begin
        first_d   = nxt_q;
        lnk_we    = 1'b1;
        lnk_waddr = cur_q;
        lnk_wdata = free_q;
        free_d    = cur_q;
        count_d   = count_q - CNT_W'(1);
      end
      DP_VICT_RD: begin
        lnk_raddr = nxt_q;
      end
      DP_VICT_UNLINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = cur_q;
        lnk_wdata = lnk_rdata_q;
      end
      DP_VICT_FREE: begin
        lnk_we    = 1'b1;
        lnk_waddr = nxt_q;
        lnk_wdata = free_q;
        free_d    = nxt_q;
        count_d   = count_q - CNT_W'(1);
      end
      DP_EMIT: begin
        ov_d   = 1'b1;
        ost_d  = status_q;
        olen_d = cnt_ext[LEN_W-1:0];
        oval_d = rd_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = ost_q;
  assign out_length_o = olen_q;
  assign out_value_o  = oval_q;

endmodule

// File: rtl/positional_linked_list_top.sv
// Top level of the positional linked list: controller plus datapath.
// Depends on pll_pkg, pll_ctrl, pll_dp and the assertion macro header.
//
//   channel  | dir | tdata (low bit up)                  | tuser
//   s_axis   | in  | value[31:0], position[40:32], pad   | cmd[2:0]
//   m_axis   | out | length[8:0], read_value[40:9], pad  | status[1:0]
//
// A word is loaded and decoded, then follows hops links, one per cycle on the link memory's
// read port; hops is at most CAPACITY - 1. A read then captures the value; a delete unlinks
// the node and frees it; an insert takes a node, with an extra step when it comes off the
// free list, and links it in. Rejected and unused commands go straight to the result. A
// finished word waits while the previous result is still unread. rst_ni clears the list
// at once; the node memories need no clearing.
`include "positional_linked_list_top_defines.svh"

module positional_linked_list_top
  import pll_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // value, position, zero pad
  input  logic [CMD_W-1:0]     s_axis_tuser,  // cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // length, read_value, zero pad
  output logic [ST_W-1:0]      m_axis_tuser   // status
);

  ctrl_t            ctrl;
  dp_stat_t         stat;
  logic [ST_W-1:0]  out_status;
  logic [LEN_W-1:0] out_length;
  logic [VAL_W-1:0] out_value;

  pll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  pll_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .in_cmd_i     (s_axis_tuser),
    .in_value_i   (s_axis_tdata[VAL_W-1:0]),
    .in_pos_i     (s_axis_tdata[VAL_W+POS_W-1:VAL_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_length_o (out_length),
    .out_value_o  (out_value)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {{(M_TDATA_W - LEN_W - VAL_W){1'b0}}, out_value, out_length};

  `PLL_ASSERT_NEXT(a_one_word_at_a_time, clk_i, rst_ni,
                   (s_axis_tvalid && s_axis_tready), (!s_axis_tready),
                   "input taken again while a word is in work")
  `PLL_ASSERT_IMPL(a_empty_has_no_length, clk_i, rst_ni,
                   (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)),
                   (m_axis_tdata[LEN_W-1:0] == '0), "empty status with nonzero length")
  `PLL_ASSERT_IMPL(a_error_reads_zero, clk_i, rst_ni,
                   (m_axis_tvalid && (m_axis_tuser != ST_OK)),
                   (m_axis_tdata[LEN_W+VAL_W-1:LEN_W] == '0),
                   "failed command returned a read value")

endmodule

// File: dv/pll_checker.sv
// Checker for the positional linked list: keeps its own copy of the list,
// predicts one result per command word and compares it with the output stream.
// Depends on pll_pkg for field widths, command and status codes.
module pll_checker
  import pll_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,   // value[31:0], position[40:32], pad
  input  logic [CMD_W-1:0]     s_tuser_i,   // cmd
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,   // length[8:0], read_value[40:9], pad
  input  logic [ST_W-1:0]      m_tuser_i,   // status
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = CAPACITY_DEF;
  localparam logic [POS_W-1:0] NO_NODE = POS_W'(NODES);

  typedef struct {
    status_e          st;
    logic [LEN_W-1:0] len;
    logic [VAL_W-1:0] rd;
  } list_result_t;

  logic [VAL_W-1:0] node_val  [NODES];
  logic [POS_W-1:0] node_next [NODES];
  logic [POS_W-1:0] head_node;
  logic [POS_W-1:0] free_node;
  logic [POS_W-1:0] fresh_node;
  int unsigned      elem_cnt;

  list_result_t expected_q[$];
  int           fail_cnt = 0;

  assign fail_count_o = fail_cnt;

  // A link that holds the null marker is folded onto node zero.
  function automatic int slot(input logic [POS_W-1:0] n);
    return (n < NODES) ? int'(n) : 0;
  endfunction

  function automatic int node_at(input int k);
    int n;
    n = slot(head_node);
    for (int i = 1; i < k; i++) n = slot(node_next[n]);
    return n;
  endfunction

  // Recycled nodes are used first, then never-used ones in order.
  function automatic int grab_node(input logic [VAL_W-1:0] v);
    int n;
    if (free_node != NO_NODE) begin
      n = slot(free_node);
      free_node = node_next[n];
    end else begin
      n = slot(fresh_node);
      fresh_node++;
    end
    node_val[n] = v;
    return n;
  endfunction

  function automatic void release_node(input int n);
    node_next[n] = free_node;
    free_node = POS_W'(n);
  endfunction

  function automatic void link_front(input logic [VAL_W-1:0] v);
    int n;
    n = grab_node(v);
    node_next[n] = head_node;
    head_node = POS_W'(n);
    elem_cnt++;
  endfunction

  function automatic void link_after(input int p, input logic [VAL_W-1:0] v);
    int prev, n;
    prev = node_at(p);
    n = grab_node(v);
    node_next[n] = node_next[prev];
    node_next[prev] = POS_W'(n);
    elem_cnt++;
  endfunction

  function automatic void unlink_front();
    int n;
    n = slot(head_node);
    head_node = node_next[n];
    release_node(n);
    elem_cnt--;
  endfunction

  function automatic void unlink_at(input int p);
    int prev, victim;
    prev = node_at(p - 1);
    victim = slot(node_next[prev]);
    node_next[prev] = node_next[victim];
    release_node(victim);
    elem_cnt--;
  endfunction

  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                  input logic [VAL_W-1:0] v,
                                                  input logic [POS_W-1:0] pos);
    list_result_t r;
    logic full, empty, pos_ok;
    full   = elem_cnt >= NODES;
    empty  = elem_cnt == 0;
    pos_ok = (pos >= 1) && (pos <= elem_cnt);
    r.st   = ST_OK;
    r.rd   = '0;
    case (cmd)
      CMD_INS_FRONT: begin
        if (full) r.st = ST_FULL;
        else link_front(v);
      end
      CMD_INS_POS: begin
        // The position is judged before the list is found full.
        if (!pos_ok) r.st = ST_BAD_POS;
        else if (full) r.st = ST_FULL;
        else if (pos == 1) link_front(v);
        else link_after(int'(pos) - 1, v);
      end
      CMD_INS_END: begin
        if (full) r.st = ST_FULL;
        else if (empty) link_front(v);
        else link_after(int'(elem_cnt), v);
      end
      CMD_DEL_FRONT: begin
        if (empty) r.st = ST_EMPTY;
        else unlink_front();
      end
      CMD_DEL_POS: begin
        if (empty) r.st = ST_EMPTY;
        else if (!pos_ok) r.st = ST_BAD_POS;
        else if (pos == 1) unlink_front();
        else unlink_at(int'(pos));
      end
      CMD_DEL_END: begin
        if (empty) r.st = ST_EMPTY;
        else if (elem_cnt == 1) unlink_front();
        else unlink_at(int'(elem_cnt));
      end
      CMD_READ: begin
        if (empty) r.st = ST_EMPTY;
        else if (!pos_ok) r.st = ST_BAD_POS;
        else r.rd = node_val[node_at(int'(pos))];
      end
      default: begin
      end
    endcase
    r.len = elem_cnt[LEN_W-1:0];
    return r;
  endfunction

  function automatic void note_fail(input string what, input logic [VAL_W-1:0] want,
                                    input logic [VAL_W-1:0] got);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s mismatch: expected %0h, got %0h", what, want, got);
  endfunction

  // A result word may still be unread when the next command word is taken; the
  // output side is handled first at each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      head_node  = NO_NODE;
      free_node  = NO_NODE;
      fresh_node = '0;
      elem_cnt   = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("result word with no command pending: status %0h, tdata %0h",
                     m_tuser_i, m_tdata_i);
          end
        end else begin
          want = expected_q.pop_front();
          if (m_tuser_i != want.st) note_fail("status", VAL_W'(want.st), VAL_W'(m_tuser_i));
          if (m_tdata_i[LEN_W-1:0] != want.len) begin
            note_fail("length", VAL_W'(want.len), VAL_W'(m_tdata_i[LEN_W-1:0]));
          end
          if (m_tdata_i[LEN_W+VAL_W-1:LEN_W] != want.rd) begin
            note_fail("read_value", want.rd, m_tdata_i[LEN_W+VAL_W-1:LEN_W]);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_q.push_back(apply_list_cmd(s_tuser_i, s_tdata_i[VAL_W-1:0],
                                            s_tdata_i[VAL_W+POS_W-1:VAL_W]));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// File: dv/tb_positional_linked_list_top.sv
// Testbench top for the positional linked list: clock, reset, command words
// with random gaps, a stalling result sink, a watchdog and the verdict.
// Depends on pll_pkg, positional_linked_list_top and pll_checker.
module tb_positional_linked_list_top
  import pll_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES       = CAPACITY_DEF;
  localparam int TOTAL_WORDS = 1800;
  localparam int IDLE_LIMIT  = 5000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // value[31:0], position[40:32], pad
  logic [CMD_W-1:0]     s_axis_tuser;   // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // length[8:0], read_value[40:9], pad
  logic [ST_W-1:0]      m_axis_tuser;   // status

  int   fail_count;
  int   pending;
  int   list_len    = 0;
  int   words_sent  = 0;
  int   idle_cycles = 0;
  int   ready_left  = 0;
  logic no_idle     = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  positional_linked_list_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pll_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  always @(posedge clk_i) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (no_idle || $urandom_range(0, 1)) begin
      m_axis_tready <= 1'b1;
      ready_left    <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b0;
      ready_left    <= idle_len() - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one command word and returns at the edge that takes it. Valid is
  // only lowered when a gap follows, so back-to-back words keep it high.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value,
                           input int pos);
    int gap;
    gap = (no_idle || $urandom_range(0, 1)) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({pos[POS_W-1:0], value});
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    words_sent++;
    // Track only the length, so that positions can be aimed inside the list.
    case (cmd)
      CMD_INS_FRONT, CMD_INS_END: if (list_len < NODES) list_len++;
      CMD_INS_POS: if (pos >= 1 && pos <= list_len && list_len < NODES) list_len++;
      CMD_DEL_FRONT, CMD_DEL_END: if (list_len > 0) list_len--;
      CMD_DEL_POS: if (pos >= 1 && pos <= list_len) list_len--;
      default: begin
      end
    endcase
  endtask

  // grow_pct sets the share of inserts among the inserts and deletes.
  task automatic random_word(input int grow_pct);
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
    int pick, pos;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      cmd = CMD_UNUSED;
    end else if (pick < 17) begin
      cmd = CMD_READ;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_INS_FRONT;
        1:       cmd = CMD_INS_POS;
        default: cmd = CMD_INS_END;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_DEL_FRONT;
        1:       cmd = CMD_DEL_POS;
        default: cmd = CMD_DEL_END;
      endcase
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      pos = $urandom_range(0, 511);
    end else if (pick == 1) begin
      case ($urandom_range(0, 2))
        0:       pos = 0;
        1:       pos = list_len;
        default: pos = list_len + 1;
      endcase
    end else begin
      pos = (list_len == 0) ? 1 : $urandom_range(1, list_len);
    end
    case ($urandom_range(0, 11))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7FFF_FFFF;
      2:       value = '0;
      3:       value = '1;
      default: value = $urandom();
    endcase
    send_word(cmd, value, pos);
  endtask

  initial begin
    int seg, grow;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Commands on an empty list, then a short list built and taken apart.
    send_word(CMD_READ,      $urandom(), 1);
    send_word(CMD_DEL_FRONT, $urandom(), 1);
    send_word(CMD_DEL_POS,   $urandom(), 1);
    send_word(CMD_DEL_END,   $urandom(), 1);
    send_word(CMD_INS_POS,   $urandom(), 1);
    send_word(CMD_INS_END,   32'h7FFF_FFFF, 0);
    send_word(CMD_DEL_END,   $urandom(), 0);
    send_word(CMD_INS_END,   32'h7FFF_FFFF, 0);
    send_word(CMD_INS_FRONT, 32'h8000_0000, 0);
    send_word(CMD_INS_POS,   32'h0000_0000, 2);
    send_word(CMD_INS_POS,   32'hFFFF_FFFF, 1);
    send_word(CMD_INS_POS,   $urandom(), 0);
    send_word(CMD_INS_POS,   $urandom(), 511);
    send_word(CMD_READ,      $urandom(), 1);
    send_word(CMD_READ,      $urandom(), 4);
    send_word(CMD_READ,      $urandom(), 0);
    send_word(CMD_READ,      $urandom(), 5);
    send_word(CMD_READ,      $urandom(), 511);
    send_word(CMD_UNUSED,    $urandom(), $urandom_range(0, 511));
    send_word(CMD_DEL_POS,   $urandom(), 0);
    send_word(CMD_DEL_POS,   $urandom(), 5);
    send_word(CMD_DEL_POS,   $urandom(), 3);
    send_word(CMD_DEL_POS,   $urandom(), 1);
    send_word(CMD_DEL_END,   $urandom(), 0);
    send_word(CMD_DEL_FRONT, $urandom(), 0);

    // Fill the store completely; front inserts keep this cheap.
    while (list_len < NODES) begin
      send_word(($urandom_range(0, 15) == 0) ? CMD_INS_POS : CMD_INS_FRONT, $urandom(),
                $urandom_range(1, 3));
    end
    send_word(CMD_INS_FRONT, $urandom(), 0);
    send_word(CMD_INS_POS,   $urandom(), NODES);
    send_word(CMD_INS_POS,   $urandom(), NODES + 1);
    send_word(CMD_INS_POS,   $urandom(), 0);
    send_word(CMD_INS_END,   $urandom(), 0);
    send_word(CMD_READ,      $urandom(), NODES);
    send_word(CMD_READ,      $urandom(), NODES + 1);
    send_word(CMD_DEL_POS,   $urandom(), NODES);
    send_word(CMD_INS_END,   $urandom(), 0);
    send_word(CMD_DEL_END,   $urandom(), 0);
    send_word(CMD_DEL_POS,   $urandom(), NODES / 2);

    // Hover around full, then drain through the free list.
    repeat (60) random_word(60);
    while (list_len > 0) random_word(10);

    while (words_sent < TOTAL_WORDS) begin
      seg     = $urandom_range(40, 160);
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0:       grow = 70;
        1:       grow = 50;
        default: grow = 30;
      endcase
      repeat (seg) random_word(grow);
    end
    no_idle = 1'b0;
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
